// File: rtl/hgp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the generational handle pool.
package hgp_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int IDX_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
  localparam int SALT_W       = 15;
  localparam int HALF_W       = 16;
  localparam int HANDLE_W     = 32;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int SLOT_INDEX_W = 10;
  localparam int SLOT_W       = SALT_W + 1;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  typedef enum logic [1:0] {
    CLS_ALLOC,
    CLS_LOOKUP,
    CLS_RELEASE,
    CLS_BAD
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [IDX_W-1:0]  idx;
    logic [SALT_W-1:0] salt;
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_GRANT,
    S_CHECK
  } state_t;

endpackage

// File: rtl/hgp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module hgp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hgp_front.sv
`timescale 1ns / 1ps
// Request front end: classifies incoming requests and buffers them in a two-entry queue.
module hgp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [hgp_pkg::ACTION_W-1:0]      action,
  input  logic [hgp_pkg::HANDLE_W-1:0]      handle,
  output logic                              q_valid,
  input  logic                              q_pop,
  output hgp_pkg::req_t                     q_head
);

  logic [hgp_pkg::HALF_W-1:0] hidx;
  logic                       in_range;
  hgp_pkg::req_t              entry;
  hgp_pkg::req_t              q_mem [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 fill;
  logic                       push;

  assign hidx     = handle[hgp_pkg::HANDLE_W-1:hgp_pkg::HALF_W];
  assign in_range = hidx < hgp_pkg::HALF_W'(hgp_pkg::SLOT_COUNT);

  always_comb begin
    entry.idx  = hidx[hgp_pkg::IDX_W-1:0];
    entry.salt = handle[hgp_pkg::SALT_W-1:0];
    unique case (action) inside
      hgp_pkg::ACT_ALLOC: begin
        entry.cls = hgp_pkg::CLS_ALLOC;
      end
      hgp_pkg::ACT_LOOKUP, hgp_pkg::ACT_RELEASE: begin
        if (!in_range || handle[hgp_pkg::SALT_W]) begin
          entry.cls = hgp_pkg::CLS_BAD;
        end else if (action == hgp_pkg::ACT_LOOKUP) begin
          entry.cls = hgp_pkg::CLS_LOOKUP;
        end else begin
          entry.cls = hgp_pkg::CLS_RELEASE;
        end
      end
      default: begin
        entry.cls = hgp_pkg::CLS_BAD;
      end
    endcase
  end

  assign req_stall = fill == 2'd2;
  assign push      = req_valid && !req_stall;
  assign q_valid   = fill != 2'd0;
  assign q_head    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// File: rtl/hgp_back.sv
`timescale 1ns / 1ps
// Request back end: slot table, free stack and the sequencer that carries out each request.
module hgp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  hgp_pkg::req_t                       q_head,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [hgp_pkg::STATUS_W-1:0]        status,
  output logic [hgp_pkg::HANDLE_W-1:0]        new_handle,
  output logic [hgp_pkg::SLOT_INDEX_W-1:0]    slot_index
);

  hgp_pkg::state_t               state;
  hgp_pkg::state_t               state_next;
  logic [hgp_pkg::IDX_W-1:0]     clr_addr;
  logic [hgp_pkg::CNT_W-1:0]     free_count;
  logic [hgp_pkg::CNT_W-1:0]     low_mark;
  hgp_pkg::cls_t                 work_cls;
  logic [hgp_pkg::IDX_W-1:0]     work_idx;
  logic [hgp_pkg::SALT_W-1:0]    work_salt;

  logic                          out_free;
  logic                          start;
  logic [hgp_pkg::CNT_W-1:0]     pop_pos;
  logic                          pop_fresh;
  logic [hgp_pkg::IDX_W-1:0]     pop_idx;
  logic                          slot_ok;
  logic                          do_push;

  logic                          slot_we;
  logic [hgp_pkg::IDX_W-1:0]     slot_waddr;
  logic [hgp_pkg::SLOT_W-1:0]    slot_wdata;
  logic [hgp_pkg::IDX_W-1:0]     slot_raddr;
  logic [hgp_pkg::SLOT_W-1:0]    slot_rdata;
  logic                          stack_we;
  logic [hgp_pkg::IDX_W-1:0]     stack_raddr;
  logic [hgp_pkg::IDX_W-1:0]     stack_rdata;

  logic                          load_rsp;
  logic [hgp_pkg::STATUS_W-1:0]  status_next;
  logic [hgp_pkg::HANDLE_W-1:0]  new_handle_next;
  logic [hgp_pkg::SLOT_INDEX_W-1:0] slot_index_next;

  hgp_ram #(
    .WIDTH (hgp_pkg::SLOT_W),
    .DEPTH (hgp_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  hgp_ram #(
    .WIDTH (hgp_pkg::IDX_W),
    .DEPTH (hgp_pkg::SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (free_count[hgp_pkg::IDX_W-1:0]),
    .wdata (work_idx),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign start     = (state == hgp_pkg::S_IDLE) && q_valid && out_free;
  assign pop_pos   = free_count - hgp_pkg::CNT_W'(1);
  // Stack entries below the lowest depth ever reached were never written; such an entry's index is its own position.
  assign pop_fresh = pop_pos < low_mark;
  assign pop_idx   = pop_fresh ? pop_pos[hgp_pkg::IDX_W-1:0] : stack_rdata;
  assign slot_ok   = slot_rdata[hgp_pkg::SALT_W] &&
                     (slot_rdata[hgp_pkg::SALT_W-1:0] == work_salt);
  assign do_push   = (state == hgp_pkg::S_CHECK) && slot_ok &&
                     (work_cls == hgp_pkg::CLS_RELEASE);

  always_comb begin
    state_next = state;
    unique case (state)
      hgp_pkg::S_CLEAR: begin
        if (clr_addr == hgp_pkg::IDX_W'(hgp_pkg::SLOT_COUNT - 1)) begin
          state_next = hgp_pkg::S_IDLE;
        end
      end
      hgp_pkg::S_IDLE: begin
        if (start) begin
          unique case (q_head.cls)
            hgp_pkg::CLS_ALLOC: begin
              if (free_count != '0) begin
                state_next = hgp_pkg::S_POP;
              end
            end
            hgp_pkg::CLS_LOOKUP, hgp_pkg::CLS_RELEASE: begin
              state_next = hgp_pkg::S_CHECK;
            end
            default: begin
              state_next = hgp_pkg::S_IDLE;
            end
          endcase
        end
      end
      hgp_pkg::S_POP: begin
        state_next = hgp_pkg::S_GRANT;
      end
      hgp_pkg::S_GRANT, hgp_pkg::S_CHECK: begin
        state_next = hgp_pkg::S_IDLE;
      end
      default: begin
        state_next = hgp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop           = 1'b0;
    slot_we         = 1'b0;
    slot_waddr      = work_idx;
    slot_wdata      = '0;
    slot_raddr      = q_head.idx;
    stack_we        = 1'b0;
    stack_raddr     = pop_pos[hgp_pkg::IDX_W-1:0];
    load_rsp        = 1'b0;
    status_next     = hgp_pkg::STATUS_BAD;
    new_handle_next = '0;
    slot_index_next = '0;
    unique case (state)
      hgp_pkg::S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_addr;
      end
      hgp_pkg::S_IDLE: begin
        q_pop = start;
        if (start) begin
          if (q_head.cls == hgp_pkg::CLS_BAD) begin
            load_rsp = 1'b1;
          end else if (q_head.cls == hgp_pkg::CLS_ALLOC && free_count == '0) begin
            load_rsp    = 1'b1;
            status_next = hgp_pkg::STATUS_FULL;
          end
        end
      end
      hgp_pkg::S_POP: begin
        slot_raddr = pop_idx;
      end
      hgp_pkg::S_GRANT: begin
        slot_we         = 1'b1;
        slot_wdata      = {1'b1, slot_rdata[hgp_pkg::SALT_W-1:0]};
        load_rsp        = 1'b1;
        status_next     = hgp_pkg::STATUS_OK;
        new_handle_next = {hgp_pkg::HALF_W'(work_idx), 1'b0,
                           slot_rdata[hgp_pkg::SALT_W-1:0]};
        slot_index_next = hgp_pkg::SLOT_INDEX_W'(work_idx);
      end
      hgp_pkg::S_CHECK: begin
        load_rsp = 1'b1;
        if (slot_ok) begin
          status_next     = hgp_pkg::STATUS_OK;
          slot_index_next = hgp_pkg::SLOT_INDEX_W'(work_idx);
        end
        if (do_push) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b0, slot_rdata[hgp_pkg::SALT_W-1:0] + hgp_pkg::SALT_W'(1)};
          stack_we   = free_count < hgp_pkg::CNT_W'(hgp_pkg::SLOT_COUNT);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_cls  <= q_head.cls;
      work_idx  <= q_head.idx;
      work_salt <= q_head.salt;
    end else if (state == hgp_pkg::S_POP) begin
      work_idx <= pop_idx;
    end
    if (load_rsp) begin
      status     <= status_next;
      new_handle <= new_handle_next;
      slot_index <= slot_index_next;
    end
    if (rst) begin
      state      <= hgp_pkg::S_CLEAR;
      clr_addr   <= '0;
      free_count <= hgp_pkg::CNT_W'(hgp_pkg::SLOT_COUNT);
      low_mark   <= hgp_pkg::CNT_W'(hgp_pkg::SLOT_COUNT);
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hgp_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + hgp_pkg::IDX_W'(1);
      end
      if (state == hgp_pkg::S_POP) begin
        free_count <= pop_pos;
        if (pop_fresh) begin
          low_mark <= pop_pos;
        end
      end else if (do_push && free_count < hgp_pkg::CNT_W'(hgp_pkg::SLOT_COUNT)) begin
        free_count <= free_count + hgp_pkg::CNT_W'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/generational_handle_pool.sv
`timescale 1ns / 1ps
// Top level of the generational handle pool: request front end and execution back end.
//
//   Channel  Handshake             Fields
//   req      req_valid/req_stall   action, handle
//   rsp      rsp_valid/rsp_stall   status, new_handle, slot_index
//
// A malformed request, and an allocate when the pool is full, is answered from the idle
// state; a lookup or release passes through the check state and an allocate through
// the pop and grant states, because of the registered reads of the free stack and slot RAMs.
// After reset all 1024 slot table entries are cleared before the first request is
// carried out; the front queue still takes up to two transfers meanwhile.
// A two-entry queue lets requests be taken while the back end works or the result stalls.
module generational_handle_pool (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [hgp_pkg::ACTION_W-1:0]       action,
  input  logic [hgp_pkg::HANDLE_W-1:0]       handle,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [hgp_pkg::STATUS_W-1:0]       status,
  output logic [hgp_pkg::HANDLE_W-1:0]       new_handle,
  output logic [hgp_pkg::SLOT_INDEX_W-1:0]   slot_index
);

  logic          q_valid;
  logic          q_pop;
  hgp_pkg::req_t q_head;

  hgp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .handle    (handle),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  hgp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_head     (q_head),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .new_handle (new_handle),
    .slot_index (slot_index)
  );

endmodule
